/* rtl/core/esc_pkg.sv */
`default_nettype none

package esc_pkg;

    typedef logic [7:0] byte_t;

    // one input transfer
    typedef struct packed {
        byte_t in_byte;
        logic  end_of_text;
    } esc_item_t;

    // one result transfer
    typedef struct packed {
        byte_t out_byte;
        logic  has_byte;
        logic  end_mark;
        logic  format_error;
    } esc_result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_LOWER_A   = 8'h61;
    localparam byte_t CH_LOWER_E   = 8'h65;
    localparam byte_t CH_LOWER_F   = 8'h66;
    localparam byte_t CH_LOWER_N   = 8'h6E;
    localparam byte_t CH_LOWER_R   = 8'h72;
    localparam byte_t CH_LOWER_T   = 8'h74;
    localparam byte_t CH_LOWER_V   = 8'h76;
    localparam byte_t CH_LOWER_X   = 8'h78;
    localparam byte_t CH_UPPER_X   = 8'h58;
    localparam byte_t CH_UPPER_A   = 8'h41;
    localparam byte_t CH_UPPER_F   = 8'h46;
    localparam byte_t CH_DIGIT_0   = 8'h30;
    localparam byte_t CH_DIGIT_9   = 8'h39;

    localparam byte_t CH_BEL = 8'h07;
    localparam byte_t CH_ESC = 8'h1B;
    localparam byte_t CH_FF  = 8'h0C;
    localparam byte_t CH_LF  = 8'h0A;
    localparam byte_t CH_CR  = 8'h0D;
    localparam byte_t CH_TAB = 8'h09;
    localparam byte_t CH_VT  = 8'h0B;

    localparam logic [1:0] HEX_DIGITS = 2'd2;

    function automatic byte_t escape_map(input byte_t c);
        byte_t r;
        unique case (c)
            CH_LOWER_A: r = CH_BEL;
            CH_LOWER_E: r = CH_ESC;
            CH_LOWER_F: r = CH_FF;
            CH_LOWER_N: r = CH_LF;
            CH_LOWER_R: r = CH_CR;
            CH_LOWER_T: r = CH_TAB;
            CH_LOWER_V: r = CH_VT;
            default:    r = c;
        endcase
        return r;
    endfunction

    function automatic nibble_t hex_nibble(input byte_t c);
        nibble_t r;
        byte_t   d;
        r = '{ok: 1'b0, value: 4'd0};
        d = 8'd0;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            d = c - CH_DIGIT_0;
            r = '{ok: 1'b1, value: d[3:0]};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            d = c - CH_LOWER_A + 8'd10;
            r = '{ok: 1'b1, value: d[3:0]};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d = c - CH_UPPER_A + 8'd10;
            r = '{ok: 1'b1, value: d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/esc_in_reg.sv */
`default_nettype none

module esc_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire esc_pkg::esc_item_t s_item,
    output logic                   item_valid,
    input  wire logic              item_take,
    output esc_pkg::esc_item_t     item
);
    import esc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    esc_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/core/esc_decode.sv */
`default_nettype none

module esc_decode (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               item_valid,
    output logic                    item_take,
    input  wire esc_pkg::esc_item_t item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output esc_pkg::esc_result_t    result
);
    import esc_pkg::*;

    logic        after_bs_reg, after_bs_next;
    logic [1:0]  hex_left_reg, hex_left_next;
    byte_t       hex_value_reg, hex_value_next;
    logic        hex_bad_reg, hex_bad_next;

    logic        out_valid_reg, out_valid_next;
    esc_result_t result_reg, result_next;

    logic        advance;
    logic        have;
    byte_t       dec_byte;
    logic        err;
    nibble_t     nib;

    assign advance   = !out_valid_reg || m_ready;
    assign item_take = item_valid && advance;
    assign nib       = hex_nibble(item.in_byte);

    always_comb begin
        after_bs_next  = after_bs_reg;
        hex_left_next  = hex_left_reg;
        hex_value_next = hex_value_reg;
        hex_bad_next   = hex_bad_reg;
        have           = 1'b0;
        dec_byte       = 8'd0;
        err            = 1'b0;

        if (after_bs_reg) begin
            after_bs_next = 1'b0;
            if (item.in_byte == CH_LOWER_X || item.in_byte == CH_UPPER_X) begin
                hex_left_next  = HEX_DIGITS;
                hex_value_next = 8'd0;
                hex_bad_next   = 1'b0;
            end else begin
                have     = 1'b1;
                dec_byte = escape_map(item.in_byte);
            end
        end else if (hex_left_reg != 2'd0) begin
            // a bad digit still uses up a slot but adds nothing
            if (!nib.ok) begin
                hex_bad_next = 1'b1;
            end else if (!hex_bad_reg) begin
                hex_value_next = {hex_value_reg[3:0], nib.value};
            end
            hex_left_next = hex_left_reg - 2'd1;
            if (hex_left_next == 2'd0) begin
                have           = 1'b1;
                dec_byte       = hex_value_next;
                err            = hex_bad_next;
                hex_value_next = 8'd0;
                hex_bad_next   = 1'b0;
            end
        end else if (item.in_byte == CH_BACKSLASH) begin
            after_bs_next = 1'b1;
        end else begin
            have     = 1'b1;
            dec_byte = item.in_byte;
        end

        // end of string: dangling backslash is an error, partial hex dropped
        if (item.end_of_text) begin
            if (after_bs_next) begin
                err = 1'b1;
            end
            after_bs_next  = 1'b0;
            hex_left_next  = 2'd0;
            hex_value_next = 8'd0;
            hex_bad_next   = 1'b0;
        end

        result_next.out_byte     = have ? dec_byte : 8'd0;
        result_next.has_byte     = have;
        result_next.end_mark     = item.end_of_text;
        result_next.format_error = err;
    end

    always_comb begin
        if (item_take) begin
            out_valid_next = have || item.end_of_text;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_bs_reg  <= 1'b0;
            hex_left_reg  <= 2'd0;
            hex_value_reg <= 8'd0;
            hex_bad_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (item_take) begin
                after_bs_reg  <= after_bs_next;
                hex_left_reg  <= hex_left_next;
                hex_value_reg <= hex_value_next;
                hex_bad_reg   <= hex_bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

endmodule

`default_nettype wire

/* rtl/core/escape_sequence_decoder.sv */
// Backslash escape decoder, one byte of text per transfer.
// Input channel s_*: s_in_byte with s_end_of_text marking the last byte of
// a string. Result channel m_*: m_out_byte valid when m_has_byte is set,
// m_end_mark closes the string, m_format_error flags a dangling backslash
// at the end or a non-hex digit inside a \x escape.
// A byte that opens an escape (backslash, x/X, first hex digit) gives no
// result unless it is also the end of the string.
// The input transfer is stored in the input register, then decoded into
// the result register, which drives m_valid and the result outputs.
// Throughput: one byte per cycle while m_ready is high; the decode
// between the two registers is combinational, and the escape state
// updates in the same cycle as the result register loads.
// When m_ready is low the result register holds and the input register
// fills; s_ready drops only once both hold an item.
// Reset (aresetn, synchronous, active low) empties both registers and
// clears the escape state, so the next byte starts a new string.
`default_nettype none

module escape_sequence_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_text,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_has_byte,
    output logic            m_end_mark,
    output logic            m_format_error
);
    import esc_pkg::*;

    esc_item_t   s_item;
    esc_item_t   item;
    logic        item_valid;
    logic        item_take;
    esc_result_t result;

    assign s_item.in_byte     = s_in_byte;
    assign s_item.end_of_text = s_end_of_text;

    esc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    esc_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result     (result)
    );

    assign m_out_byte     = result.out_byte;
    assign m_has_byte     = result.has_byte;
    assign m_end_mark     = result.end_mark;
    assign m_format_error = result.format_error;

endmodule

`default_nettype wire

/* rtl/core/esc_checker.sv */
`default_nettype none

module esc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_has_byte,
    input wire logic       m_end_mark,
    input wire logic       m_format_error
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_has_byte) && $stable(m_end_mark) && $stable(m_format_error))
        else $error("result changed while stalled");

    // reset leaves the result channel empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a result without a byte only closes a string
    a_empty_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_byte |-> m_end_mark && m_out_byte == 8'd0)
        else $error("byteless result not at end of string");

    // an error comes with a bad hex byte or at the end of the string
    a_error_context: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_format_error |-> m_has_byte || m_end_mark)
        else $error("format error without context");

    // with the output free, the input side never stalls
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with output free");

endmodule

bind escape_sequence_decoder esc_checker u_esc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_has_byte     (m_has_byte),
    .m_end_mark     (m_end_mark),
    .m_format_error (m_format_error)
);

`default_nettype wire
